// ===== hdl/dtr_pkg.sv =====
package dtr_pkg;

    localparam int KindWidth  = 3;
    localparam int ByteWidth  = 8;
    localparam int DivWidth   = 16;
    localparam int CtrlWidth  = 3;
    localparam int OutWidth   = 24;

    // Each machine cycle adds this amount to the divider.
    localparam logic [DivWidth-1:0] DivStep = 16'd4;

    typedef enum logic [KindWidth-1:0] {
        KIND_NONE      = 3'd0,
        KIND_WR_COUNT  = 3'd1,
        KIND_WR_MODULO = 3'd2,
        KIND_WR_CTRL   = 3'd3,
        KIND_DIV_RESET = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        SEL_BIT9 = 2'd0,
        SEL_BIT3 = 2'd1,
        SEL_BIT5 = 2'd2,
        SEL_BIT7 = 2'd3
    } sel_t;

    // Divider bit picked by the control select field, gated by the enable bit.
    function automatic logic tick_signal(input logic [DivWidth-1:0]  div,
                                         input logic [CtrlWidth-1:0] ctrl);
        logic b;
        begin
            case (sel_t'(ctrl[1:0]))
                SEL_BIT9: b = div[9];
                SEL_BIT3: b = div[3];
                SEL_BIT5: b = div[5];
                SEL_BIT7: b = div[7];
                default:  b = div[9];
            endcase
            return b & ctrl[2];
        end
    endfunction

endpackage

// ===== hdl/divider_timer_with_reload.sv =====
// Divider and timer counter with delayed reload. Every input transfer is one
// machine cycle: an optional register write (kind on tuser, byte on tdata) is
// applied, the 16-bit divider advances by 4, and a falling edge of the selected
// divider bit (gated by the enable bit) increments the counter. An overflow
// reloads the counter from the modulo register in the next machine cycle and flags
// timer_irq in that cycle's result; a counter write in that cycle cancels the
// reload, and a counter write in the cycle after it is overridden by modulo.
// Each transfer yields exactly one result, registered when it is accepted. The
// whole step is one pass of logic from the state registers into the state and
// the output register, so a new transfer is taken every clock; the output
// register frees in the same cycle it is read, so s_axis_tready only drops
// while a result waits and the downstream side holds m_axis_tready low.
module divider_timer_with_reload (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] write_data
    input  logic [2:0]  s_axis_tuser,   // [2:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [7:0] counter_value, [15:8] divider_high,
                                        // [16] timer_irq, [23:17] zero
);
    import dtr_pkg::*;

    logic [DivWidth-1:0]  div_reg, div_next;
    logic [ByteWidth-1:0] count_reg, count_next;
    logic [ByteWidth-1:0] modulo_reg, modulo_next;
    logic [CtrlWidth-1:0] ctrl_reg, ctrl_next;
    logic                 pending_reg, pending_next;
    logic                 hold_reg, hold_next;
    logic                 last_sig_reg, sig_next;
    logic                 irq_next;
    logic                 out_valid_reg;
    logic [OutWidth-1:0]  out_data_reg;
    logic                 in_fire;
    logic                 written;
    kind_t                kind;

    assign kind          = kind_t'(s_axis_tuser);
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        written     = (kind == KIND_WR_COUNT);
        modulo_next = (kind == KIND_WR_MODULO) ? s_axis_tdata : modulo_reg;
        ctrl_next   = (kind == KIND_WR_CTRL) ? s_axis_tdata[CtrlWidth-1:0] : ctrl_reg;
        div_next    = ((kind == KIND_DIV_RESET) ? '0 : div_reg) + DivStep;
        count_next  = written ? s_axis_tdata : count_reg;
        hold_next   = 1'b0;
        irq_next    = 1'b0;

        // The cycle after a reload keeps the counter pinned to modulo.
        if (hold_reg)
        begin
            count_next = modulo_next;
        end
        if (pending_reg && !written)
        begin
            hold_next  = 1'b1;
            count_next = modulo_next;
            irq_next   = 1'b1;
        end

        sig_next     = tick_signal(div_next, ctrl_next);
        pending_next = 1'b0;
        if (!sig_next && last_sig_reg)
        begin
            count_next   = count_next + 8'd1;
            pending_next = (count_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg       <= '0;
            count_reg     <= '0;
            modulo_reg    <= '0;
            ctrl_reg      <= '0;
            pending_reg   <= 1'b0;
            hold_reg      <= 1'b0;
            last_sig_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                div_reg      <= div_next;
                count_reg    <= count_next;
                modulo_reg   <= modulo_next;
                ctrl_reg     <= ctrl_next;
                pending_reg  <= pending_next;
                hold_reg     <= hold_next;
                last_sig_reg <= sig_next;
            end
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= {7'd0, irq_next, div_next[15:8], count_next};
        end
    end

endmodule

// ===== hdl/dtr_checker.sv =====
module dtr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    import dtr_pkg::*;

    logic                 in_fire;
    logic                 out_fire;
    logic [ByteWidth-1:0] modulo_reg, modulo_next;
    logic [ByteWidth-1:0] item_modulo_reg;

    assign in_fire     = s_axis_tvalid && s_axis_tready;
    assign out_fire    = m_axis_tvalid && m_axis_tready;
    assign modulo_next = (kind_t'(s_axis_tuser) == KIND_WR_MODULO) ? s_axis_tdata : modulo_reg;

    // Shadow of the modulo register as seen by the transfer now in the output slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulo_reg      <= '0;
            item_modulo_reg <= '0;
        end
        else if (in_fire)
        begin
            modulo_reg      <= modulo_next;
            item_modulo_reg <= modulo_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while stalled");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> m_axis_tvalid)
        else $error("accepted transfer did not produce a result");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output slot");

    a_irq_reload: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && m_axis_tdata[16] |->
            (m_axis_tdata[7:0] == item_modulo_reg) ||
            (m_axis_tdata[7:0] == item_modulo_reg + 8'd1))
        else $error("interrupt without a reload from modulo");

endmodule

bind divider_timer_with_reload dtr_checker u_dtr_checker (.*);
